/* rtl/core/s256_pkg.sv */
package s256_pkg;

  typedef logic [31:0] word_t;

  // working variables a..h, index 0 is a
  typedef logic [7:0][31:0] work_t;

  typedef struct packed {
    logic       shift_in;
    logic       step;
    logic [7:0] din;
  } sched_ctl_t;

  localparam work_t IV_HASH = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [31:0] BLOCK_BITS = 32'd512;

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    unique case (r)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/s256_msg_sched.sv */
module s256_msg_sched (
  input  logic                 clk,
  input  s256_pkg::sched_ctl_t ctl,
  output s256_pkg::word_t      wt
);
  import s256_pkg::*;

  // index 15 holds the oldest word
  logic [15:0][31:0] win_r;
  logic [15:0][31:0] win_nxt;
  word_t             w_new;

  assign w_new = ssig1(win_r[1]) + win_r[6] + ssig0(win_r[14]) + win_r[15];
  assign wt    = win_r[15];

  always_comb begin
    win_nxt = win_r;
    if (ctl.shift_in) begin
      win_nxt = {win_r[15][23:0], win_r[14:0], ctl.din};
    end else if (ctl.step) begin
      win_nxt = {win_r[14:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

/* rtl/core/s256_round.sv */
module s256_round (
  input  s256_pkg::work_t v,
  input  s256_pkg::word_t k,
  input  s256_pkg::word_t w,
  output s256_pkg::work_t v_nxt
);
  import s256_pkg::*;

  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;

  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + bsig1(v[4]) + ch + k + w;
  assign t2    = bsig0(v[0]) + maj;
  assign v_nxt = {v[6], v[5], v[4], v[3] + t1, v[2], v[1], v[0], t1 + t2};

endmodule

/* rtl/core/sha256_byte_stream_hasher_core.sv */
// channel | ports                        | contents
// input   | in_tvalid/in_tready          | in_tdata[7:0] data byte, in_tuser finish flag
// output  | out_tvalid/out_tready        | out_tdata[31:0] digest word, [34:32] word index
//         |                              | out_tlast on the eighth word
// data bytes are taken while idle; every 64th byte starts 64 rounds and the
// feed-forward add in the single round unit, and no byte is taken until they end
// finish writes pad bytes one per cycle up to byte 56, then 8 length bytes, then
// the rounds per block (two blocks when 56 or more bytes were held), then 8 words
// in_tready is high only while idle; output words hold while out_tready is low
// rst_n is synchronous; the hash returns to its initial value after each digest
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word, word_index, zero fill
  output logic        out_tlast   // last_word
);
  import s256_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t      st_r, st_nxt;
  work_t       chain_r, chain_nxt;
  work_t       work_r, work_nxt;
  work_t       round_out;
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] bitlen_r, bitlen_nxt;
  logic [31:0] total_r, total_nxt;
  logic        fin_r, fin_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  len_byte;
  sched_ctl_t  sctl;
  word_t       wt;

  s256_msg_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .wt  (wt)
  );

  s256_round u_round (
    .v     (work_r),
    .k     (round_k(rnd_r)),
    .w     (wt),
    .v_nxt (round_out)
  );

  // length field bytes 0..3 are zero, bytes 4..7 the bit count
  always_comb begin
    len_byte = 8'h00;
    if (fill_r[2]) begin
      case (fill_r[1:0])
        2'd0:    len_byte = total_r[31:24];
        2'd1:    len_byte = total_r[23:16];
        2'd2:    len_byte = total_r[15:8];
        default: len_byte = total_r[7:0];
      endcase
    end
  end

  always_comb begin
    st_nxt     = st_r;
    chain_nxt  = chain_r;
    work_nxt   = work_r;
    fill_nxt   = fill_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    bitlen_nxt = bitlen_r;
    total_nxt  = total_r;
    fin_nxt    = fin_r;
    done_nxt   = done_r;
    sctl       = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sctl.shift_in = 1'b1;
          fill_nxt      = fill_r + 6'd1;
          if (in_tuser) begin
            sctl.din  = PAD_BYTE;
            total_nxt = bitlen_r + {23'd0, fill_r, 3'd0};
            fin_nxt   = 1'b1;
            st_nxt    = ST_PAD;
          end else begin
            sctl.din = in_tdata;
          end
          if (&fill_r) begin
            st_nxt   = ST_ROUND;
            rnd_nxt  = '0;
            work_nxt = chain_r;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == LEN_POS) begin
          st_nxt = ST_LEN;
        end else begin
          sctl.shift_in = 1'b1;
          fill_nxt      = fill_r + 6'd1;
          if (&fill_r) begin
            st_nxt   = ST_ROUND;
            rnd_nxt  = '0;
            work_nxt = chain_r;
          end
        end
      end
      ST_LEN: begin
        sctl.shift_in = 1'b1;
        sctl.din      = len_byte;
        fill_nxt      = fill_r + 6'd1;
        if (&fill_r) begin
          st_nxt   = ST_ROUND;
          rnd_nxt  = '0;
          work_nxt = chain_r;
          done_nxt = 1'b1;
        end
      end
      ST_ROUND: begin
        sctl.step = 1'b1;
        work_nxt  = round_out;
        rnd_nxt   = rnd_r + 6'd1;
        if (&rnd_r) begin
          st_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        bitlen_nxt = bitlen_r + BLOCK_BITS;
        if (!fin_r) begin
          st_nxt = ST_IDLE;
        end else if (done_r) begin
          st_nxt  = ST_EMIT;
          idx_nxt = '0;
        end else begin
          st_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (&idx_r) begin
            chain_nxt  = IV_HASH;
            fill_nxt   = '0;
            bitlen_nxt = '0;
            fin_nxt    = 1'b0;
            done_nxt   = 1'b0;
            st_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      chain_r  <= IV_HASH;
      fill_r   <= '0;
      rnd_r    <= '0;
      idx_r    <= '0;
      bitlen_r <= '0;
      fin_r    <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      chain_r  <= chain_nxt;
      fill_r   <= fill_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      bitlen_r <= bitlen_nxt;
      fin_r    <= fin_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    total_r <= total_nxt;
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_EMIT);
  assign out_tdata  = {5'd0, idx_r, chain_r[idx_r]};
  assign out_tlast  = &idx_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while digest words are pending");

  a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FOLD) |-> ($past(st_r) == ST_ROUND) && ($past(rnd_r) == 6'd63))
    else $error("feed-forward add without a full set of rounds");

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (out_tdata[34:32] == 3'd0))
    else $error("digest does not start at word zero");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && (fill_r == 6'd0))
    else $error("not idle and empty after the last digest word");

endmodule
